/* hw/rtl/dttf_pkg.sv */
// ----------------------------------------------------------------------------
// dttf_pkg: shared types and constants for the decimal text parser
// Character codes, field widths, controller/datapath command and status
// structs, and the power-of-ten divisor table.
// ----------------------------------------------------------------------------
package dttf_pkg;

	localparam int BYTE_W   = 8;
	localparam int VALUE_W  = 48;
	localparam int FCNT_W   = 4;
	localparam int POW10_W  = 50;

	localparam int MAX_FRACTION_DIGITS_DEF = 9;
	localparam int FRACTION_BITS_DEF       = 16;

	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;

	localparam logic [VALUE_W-1:0] MANT_MAX  = {VALUE_W{1'b1}};
	localparam logic [VALUE_W-1:0] LIMIT_POS = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] LIMIT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      saturated;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;       // drop the scanned number
		logic add_digit;   // fold the current digit into the mantissa
		logic count_frac;  // advance the fraction digit count
		logic set_neg;     // mark the number negative
		logic div_load;    // copy the scanned number into the divider
		logic div_step;    // advance the divider by one quotient bit
		logic out_load;    // move the finished quotient into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_nul;
		logic is_digit;
		logic is_minus;
		logic is_plus;
		logic is_point;
		logic frac_full;
		logic div_last;
		logic out_free;
	} sts_t;

	function automatic logic [POW10_W-1:0] pow10(input logic [FCNT_W-1:0] n);
		logic [POW10_W-1:0] p;
		case (n)
			4'd0:    p = 50'd1;
			4'd1:    p = 50'd10;
			4'd2:    p = 50'd100;
			4'd3:    p = 50'd1000;
			4'd4:    p = 50'd10000;
			4'd5:    p = 50'd100000;
			4'd6:    p = 50'd1000000;
			4'd7:    p = 50'd10000000;
			4'd8:    p = 50'd100000000;
			4'd9:    p = 50'd1000000000;
			4'd10:   p = 50'd10000000000;
			4'd11:   p = 50'd100000000000;
			4'd12:   p = 50'd1000000000000;
			4'd13:   p = 50'd10000000000000;
			4'd14:   p = 50'd100000000000000;
			4'd15:   p = 50'd1000000000000000;
			default: p = 50'd1;
		endcase
		return p;
	endfunction

endpackage

/* hw/rtl/dttf_stream_if.sv */
// ----------------------------------------------------------------------------
// dttf_stream_if: valid/ready channel
// One beat moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface dttf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dttf_ctrl.sv */
// ----------------------------------------------------------------------------
// dttf_ctrl: scan and divide sequencer
// Tracks the syntax phase of the string and steps the divider at the end.
// ----------------------------------------------------------------------------
module dttf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dttf_pkg::sts_t   sts,
	output dttf_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_SKIP,
		S_MINUS,
		S_PLUS,
		S_INT,
		S_FRAC,
		S_DONE,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q != S_DIV) && (state_q != S_OUT);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_SKIP;
				end
			end
			default: begin
				if (accept) begin
					if (sts.is_nul) begin
						cmd.div_load = 1'b1;
						cmd.clear    = 1'b1;
						state_d      = S_DIV;
					end else begin
						case (state_q)
							S_SKIP: begin
								if (sts.is_minus) begin
									cmd.set_neg = 1'b1;
									state_d     = S_MINUS;
								end else if (sts.is_plus) begin
									state_d = S_PLUS;
								end else if (sts.is_point) begin
									state_d = S_FRAC;
								end else if (sts.is_digit) begin
									cmd.add_digit = 1'b1;
									state_d       = S_INT;
								end
							end
							S_MINUS, S_PLUS, S_INT: begin
								if (state_q == S_MINUS && sts.is_plus) begin
									state_d = S_PLUS;
								end else if (sts.is_point) begin
									state_d = S_FRAC;
								end else if (sts.is_digit) begin
									cmd.add_digit = 1'b1;
									state_d       = S_INT;
								end else begin
									state_d = S_DONE;
								end
							end
							S_FRAC: begin
								if (sts.is_digit) begin
									// drop digits past the cap, stay in the fraction
									if (!sts.frac_full) begin
										cmd.add_digit  = 1'b1;
										cmd.count_frac = 1'b1;
									end
								end else begin
									state_d = S_DONE;
								end
							end
							default: begin
								state_d = S_DONE;
							end
						endcase
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SKIP;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/dttf_dp.sv */
// ----------------------------------------------------------------------------
// dttf_dp: mantissa accumulator, restoring divider and output register
// Builds the decimal mantissa, divides mantissa * 2^FRACTION_BITS by the
// power of ten one quotient bit per cycle, then clamps, negates and holds
// the result for the receiver.
// ----------------------------------------------------------------------------
module dttf_dp #(
	parameter int MAX_FRACTION_DIGITS = dttf_pkg::MAX_FRACTION_DIGITS_DEF,
	parameter int FRACTION_BITS       = dttf_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [dttf_pkg::BYTE_W-1:0]        in_byte,
	input  dttf_pkg::cmd_t                     cmd,
	output dttf_pkg::sts_t                     sts,
	dttf_stream_if.source                      result
);

	localparam int VW  = dttf_pkg::VALUE_W;
	localparam int PW  = dttf_pkg::POW10_W;
	localparam int FW  = dttf_pkg::FCNT_W;
	localparam int DW  = VW + FRACTION_BITS;
	localparam int CW  = $clog2(DW);
	localparam int AW  = VW + 4;

	// scan state
	logic [VW-1:0] mant_q;
	logic [FW-1:0] fcnt_q;
	logic          neg_q;
	logic          ovf_q;

	// divider state
	logic [DW-1:0] dq_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] div_q;
	logic          dneg_q;
	logic          dovf_q;
	logic [CW-1:0] cnt_q;

	// output register
	logic                  out_valid_q;
	dttf_pkg::out_beat_t   out_q;

	logic [3:0]    digit;
	logic [AW-1:0] acc;
	logic [PW:0]   trial;
	logic [PW:0]   diff;
	logic          ge;
	logic [VW-1:0] lim;
	logic          clamp;
	logic [VW-1:0] mag;

	assign digit = in_byte[3:0] - dttf_pkg::CHAR_0[3:0];
	assign acc   = (AW'(mant_q) << 3) + (AW'(mant_q) << 1) + AW'(digit);

	assign trial = {rem_q, dq_q[DW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	assign lim   = dneg_q ? dttf_pkg::LIMIT_NEG : dttf_pkg::LIMIT_POS;
	assign clamp = (dq_q > DW'(lim));
	assign mag   = clamp ? lim : dq_q[VW-1:0];

	always_comb begin
		sts           = '0;
		sts.is_nul    = (in_byte == dttf_pkg::CHAR_NUL);
		sts.is_digit  = (in_byte >= dttf_pkg::CHAR_0) && (in_byte <= dttf_pkg::CHAR_9);
		sts.is_minus  = (in_byte == dttf_pkg::CHAR_MINUS);
		sts.is_plus   = (in_byte == dttf_pkg::CHAR_PLUS);
		sts.is_point  = (in_byte == dttf_pkg::CHAR_POINT);
		sts.frac_full = (fcnt_q >= FW'(MAX_FRACTION_DIGITS));
		sts.div_last  = (cnt_q == CW'(DW - 1));
		sts.out_free  = !out_valid_q || result.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mant_q <= '0;
			fcnt_q <= '0;
			neg_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				mant_q <= '0;
				fcnt_q <= '0;
				neg_q  <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				if (cmd.add_digit) begin
					// saturate the mantissa when ten times it plus the digit overflows
					if (acc > AW'(dttf_pkg::MANT_MAX)) begin
						mant_q <= dttf_pkg::MANT_MAX;
						ovf_q  <= 1'b1;
					end else begin
						mant_q <= acc[VW-1:0];
					end
				end
				if (cmd.count_frac) begin
					fcnt_q <= fcnt_q + FW'(1);
				end
				if (cmd.set_neg) begin
					neg_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dq_q   <= DW'(mant_q) << FRACTION_BITS;
			rem_q  <= '0;
			div_q  <= dttf_pkg::pow10(fcnt_q);
			dneg_q <= neg_q;
			dovf_q <= ovf_q;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[DW-2:0], ge};
			rem_q <= ge ? diff[PW-1:0] : trial[PW-1:0];
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.value     <= dneg_q ? (VW'(0) - mag) : mag;
			out_q.saturated <= dovf_q || clamp;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

/* hw/rtl/decimal_text_to_fixed_point.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point: decimal string to signed fixed point
// Scans an ASCII string beat by beat and emits the parsed number with
// FRACTION_BITS fraction bits when the terminating zero byte arrives.
// ----------------------------------------------------------------------------
// Channels: text carries one character per beat (text_byte); a zero byte
// ends the string. result carries one beat per string: value (48-bit two's
// complement, FRACTION_BITS fraction bits, truncated toward zero) and
// saturated (mantissa overflow or result clamped to the 48-bit range).
// Throughput: ordinary characters are taken one per cycle. The terminator
// starts a restoring divide of mantissa * 2^FRACTION_BITS by ten to the
// fraction digit count, one quotient bit per cycle; text stalls from the
// terminator until the quotient is loaded into the output register.
// Stall: the result sits in an output register; while it waits, the next
// string is scanned. A finished divide holds until the register is free.
// Reset: arst_n clears the scan state and the output valid at once; the
// block is ready for text on the first cycle after reset.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point #(
	parameter int MAX_FRACTION_DIGITS = dttf_pkg::MAX_FRACTION_DIGITS_DEF,
	parameter int FRACTION_BITS       = dttf_pkg::FRACTION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dttf_stream_if.sink   text,
	dttf_stream_if.source result
);

	dttf_pkg::cmd_t cmd;
	dttf_pkg::sts_t sts;
	logic           in_ready;

	// hand the text ready straight from the sequencer
	assign text.ready = in_ready;

	dttf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dttf_dp #(
		.MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
		.FRACTION_BITS       (FRACTION_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (text.data.text_byte),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule

/* tb/decimal_text_to_fixed_point_tb.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_tb: self-checking bench for the decimal parser
// Streams ASCII strings into the text channel, predicts every parsed number
// with an independent scanner and divider, and checks each result beat
// field by field under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_tb;
	import dttf_pkg::*;

	localparam int FRAC_BITS    = FRACTION_BITS_DEF;
	localparam int FRAC_CAP     = MAX_FRACTION_DIGITS_DEF;
	localparam int RANDOM_BYTES = 940;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 150;
	localparam int LONG_HOLD    = 600;

	typedef enum logic [2:0] {
		SCAN_SKIP,
		SCAN_MINUS,
		SCAN_PLUS,
		SCAN_INT,
		SCAN_FRAC,
		SCAN_DONE
	} scan_phase_e;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_CYCLIC
	} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	dttf_stream_if #(.payload_t(in_beat_t))  text_ch ();
	dttf_stream_if #(.payload_t(out_beat_t)) result_ch ();

	decimal_text_to_fixed_point uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	// Scanner state of the predictor, advanced on every accepted text beat.
	scan_phase_e      scan_phase;
	logic [VALUE_W-1:0] scan_mant;
	logic [FCNT_W-1:0]  scan_fdigits;
	logic             scan_neg;
	logic             scan_ovf;

	// Parsed numbers still owed by the block, oldest first.
	out_beat_t expected_numbers[$];

	int error_count = 0;
	int sent_bytes = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int long_hold_cycles = 0;

	// Receiver-side pacing state.
	rx_mode_e rx_mode = RX_STEADY;
	int       rx_timer = 0;
	int       rx_hold_left = 0;
	int       rx_step = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run; the limit is many times the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_scan();
		scan_phase   = SCAN_SKIP;
		scan_mant    = '0;
		scan_fdigits = '0;
		scan_neg     = 1'b0;
		scan_ovf     = 1'b0;
	endfunction

	// Append one decimal digit; pin the mantissa at all ones once it would wrap.
	function automatic void fold_digit(input logic [7:0] c);
		logic [63:0] d;
		logic [63:0] room;
		d    = 64'(c - CHAR_0);
		room = (64'(MANT_MAX) - d) / 64'd10;
		if (64'(scan_mant) > room) begin
			scan_mant = MANT_MAX;
			scan_ovf  = 1'b1;
		end else begin
			scan_mant = VALUE_W'(64'(scan_mant) * 64'd10 + d);
		end
	endfunction

	// mantissa * 2^FRAC_BITS / 10^digits, truncated, clamped, then signed.
	function automatic out_beat_t convert_scan();
		logic [63:0] divisor;
		logic [63:0] whole;
		logic [63:0] rem;
		logic [63:0] frac;
		logic [63:0] mag;
		logic [63:0] limit;
		logic        sat;
		out_beat_t   num;
		divisor = 64'd1;
		for (int i = 0; i < int'(scan_fdigits); i++)
			divisor = divisor * 64'd10;
		whole = 64'(scan_mant) / divisor;
		rem   = 64'(scan_mant) % divisor;
		frac  = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			rem  = rem << 1;
			frac = frac << 1;
			if (rem >= divisor) begin
				rem     = rem - divisor;
				frac[0] = 1'b1;
			end
		end
		sat   = scan_ovf;
		limit = scan_neg ? 64'(LIMIT_NEG) : 64'(LIMIT_POS);
		if (whole > (limit >> FRAC_BITS)) begin
			mag = limit;
			sat = 1'b1;
		end else begin
			mag = (whole << FRAC_BITS) | frac;
			if (mag > limit) begin
				mag = limit;
				sat = 1'b1;
			end
		end
		if (scan_neg)
			mag = 64'd0 - mag;
		num.value     = mag[VALUE_W-1:0];
		num.saturated = sat;
		return num;
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		logic dig;
		dig = (c >= CHAR_0) && (c <= CHAR_9);
		if (c == CHAR_NUL) begin
			expected_numbers.push_back(convert_scan());
			clear_scan();
			return;
		end
		case (scan_phase)
			SCAN_SKIP: begin
				if (c == CHAR_MINUS) begin
					scan_neg   = 1'b1;
					scan_phase = SCAN_MINUS;
				end else if (c == CHAR_PLUS) begin
					scan_phase = SCAN_PLUS;
				end else if (c == CHAR_POINT) begin
					scan_phase = SCAN_FRAC;
				end else if (dig) begin
					fold_digit(c);
					scan_phase = SCAN_INT;
				end
			end
			SCAN_MINUS, SCAN_PLUS, SCAN_INT: begin
				if (scan_phase == SCAN_MINUS && c == CHAR_PLUS) begin
					scan_phase = SCAN_PLUS;
				end else if (c == CHAR_POINT) begin
					scan_phase = SCAN_FRAC;
				end else if (dig) begin
					fold_digit(c);
					scan_phase = SCAN_INT;
				end else begin
					scan_phase = SCAN_DONE;
				end
			end
			SCAN_FRAC: begin
				// digits past the cap are dropped but keep the fraction phase
				if (dig) begin
					if (int'(scan_fdigits) < FRAC_CAP) begin
						fold_digit(c);
						scan_fdigits++;
					end
				end else begin
					scan_phase = SCAN_DONE;
				end
			end
			default: scan_phase = SCAN_DONE;
		endcase
	endfunction

	// ---------------------------------------------------------------- result side

	// Receiver pacing: random modes held for random stretches, plus a long
	// hold-off on request, counted here in cycles.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (long_hold_cycles > 0) begin
				rx_hold_left     = long_hold_cycles;
				long_hold_cycles = 0;
			end
			if (rx_timer == 0) begin
				rx_mode  = rx_mode_e'($urandom_range(0, 3));
				rx_timer = $urandom_range(32, 256);
			end
			rx_timer--;
			rx_step++;
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY: result_ch.ready <= 1'b1;
					RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   result_ch.ready <= ((rx_step % 5) < 3);
				endcase
			end
		end
	end

	// Compare each result beat against the oldest owed number.
	always @(posedge clk) begin
		out_beat_t want;
		out_beat_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_numbers.size() == 0) begin
				$error("result beat with no string pending: value %0d saturated %0b",
					got.value, got.saturated);
				error_count++;
			end else begin
				want = expected_numbers.pop_front();
				if (got.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, got.value);
					error_count++;
				end
				if (got.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated,
						got.saturated);
					error_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- text side

	// Send one character. The sender runs in bursts; between bursts it may drop
	// valid for a random gap. Valid stays high across back-to-back beats.
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				text_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		text_ch.valid          <= 1'b1;
		text_ch.data.text_byte <= c;
		do @(posedge clk); while (!text_ch.ready);
		scan_char(c);
		sent_bytes++;
	endtask

	// Drop valid before the sender goes quiet.
	task automatic release_text();
		@(negedge clk);
		text_ch.valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
		send_char(CHAR_NUL);
	endtask

	// Any nonzero byte that does not start a number.
	function automatic logic [7:0] random_filler();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while ((c >= CHAR_0 && c <= CHAR_9) || c == CHAR_MINUS || c == CHAR_PLUS ||
			c == CHAR_POINT);
		return c;
	endfunction

	function automatic logic [7:0] random_noise();
		string pool;
		pool = "0123456789+-.";
		if ($urandom_range(0, 1) == 0)
			return pool[$urandom_range(0, pool.len() - 1)];
		return 8'($urandom_range(1, 255));
	endfunction

	// Mostly well-formed numbers with random content; the rest is noise.
	task automatic send_random_string();
		logic [7:0] chars[$];
		int         n;
		if ($urandom_range(0, 9) < 8) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) chars.push_back(random_filler());
			case ($urandom_range(0, 5))
				0: chars.push_back(CHAR_MINUS);
				1: chars.push_back(CHAR_PLUS);
				2: begin
					chars.push_back(CHAR_MINUS);
					chars.push_back(CHAR_PLUS);
				end
				default: ;
			endcase
			// long integer parts reach the clamp and mantissa overflow
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 6);
			repeat (n) chars.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
			if ($urandom_range(0, 2) != 0) begin
				chars.push_back(CHAR_POINT);
				repeat ($urandom_range(0, 11)) chars.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(1, 12)) chars.push_back(random_noise());
		end
		foreach (chars[i])
			send_char(chars[i]);
		send_char(CHAR_NUL);
	endtask

	// ---------------------------------------------------------------- tests

	// Strings without digits, and negative zero, all give zero.
	task automatic test_no_digits();
		send_string("");
		send_string("-");
		send_string("+");
		send_string(".");
		send_string("-.");
		send_string("+-7");
		send_string("-0");
	endtask

	// Ordinary numbers, signs, and junk (high-bit bytes too) before the number.
	task automatic test_plain_numbers();
		send_string("12.5");
		send_string("-+0.0625");
		send_string("+3.14159");
		send_char(8'hFF);
		send_char(8'h80);
		send_char(8'h7F);
		send_string("x 42");
		send_string("9.");
	endtask

	// A second point, a second sign or any stray byte ends the scan.
	task automatic test_scan_end();
		send_string("1.2.3");
		send_string("--5");
		send_string("3x9");
		send_string("-.5.5");
	endtask

	// Fraction digits past the cap are dropped.
	task automatic test_fraction_cap();
		send_string("0.123456789987");
		send_string("-1.00000000001");
	endtask

	// Clamp to the 48-bit range on both signs, and mantissa overflow.
	task automatic test_range_limits();
		send_string("281474976710655");
		send_string("2814749767106559");
		send_string("28147497.67106559");
		send_string("2147483647.99999");
		send_string("2147483648");
		send_string("-2147483648");
		send_string("-2147483648.00001");
		send_string("-0.000000001");
	endtask

	// Hold the result side off for a long stretch while text keeps coming,
	// so the output register and the finished divide back up into text.
	task automatic test_output_backpressure();
		long_hold_cycles = LONG_HOLD;
		repeat (8) send_random_string();
	endtask

	// Pause the sender until every owed number has come out, then resume.
	task automatic test_drain_pause();
		release_text();
		while (expected_numbers.size() != 0) @(posedge clk);
		repeat (10) send_random_string();
	endtask

	task automatic test_random_strings();
		int start;
		start = sent_bytes;
		while (sent_bytes - start < RANDOM_BYTES)
			send_random_string();
	endtask

	initial begin
		text_ch.valid          = 1'b0;
		text_ch.data.text_byte = CHAR_NUL;
		result_ch.ready        = 1'b0;
		arst_n                 = 1'b0;
		clear_scan();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_no_digits();
		test_plain_numbers();
		test_scan_end();
		test_fraction_cap();
		test_range_limits();
		test_output_backpressure();
		test_drain_pause();
		test_random_strings();

		// Wait out the last divides, then give stray beats a chance to show.
		release_text();
		while (expected_numbers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/dttf_pkg.sv
hw/rtl/dttf_stream_if.sv
hw/rtl/dttf_ctrl.sv
hw/rtl/dttf_dp.sv
hw/rtl/decimal_text_to_fixed_point.sv
tb/decimal_text_to_fixed_point_tb.sv
